// ===== rtl/core/thv_pkg.sv =====
// ----------------------------------------------------------------------------
// thv_pkg
// shared types and constants for the tcp header validator
// ----------------------------------------------------------------------------
`default_nettype none

package thv_pkg;

  typedef enum logic [1:0] {
    PH_FIXED = 2'd0,
    PH_KIND  = 2'd1,
    PH_BODY  = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  localparam logic [7:0] K_EOL  = 8'd0;
  localparam logic [7:0] K_NOP  = 8'd1;
  localparam logic [7:0] K_MSS  = 8'd2;
  localparam logic [7:0] K_WS   = 8'd3;
  localparam logic [7:0] K_SACK = 8'd4;
  localparam logic [7:0] K_TS   = 8'd8;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_SHORT     = 4'd1;
  localparam logic [3:0] ST_SRC0      = 4'd2;
  localparam logic [3:0] ST_DST0      = 4'd3;
  localparam logic [3:0] ST_ALLFLAGS  = 4'd4;
  localparam logic [3:0] ST_NOFLAGS   = 4'd5;
  localparam logic [3:0] ST_SYNFIN    = 4'd6;
  localparam logic [3:0] ST_MSS_REP   = 4'd7;
  localparam logic [3:0] ST_SACK_REP  = 4'd8;
  localparam logic [3:0] ST_TS_REP    = 4'd9;
  localparam logic [3:0] ST_TS_LEN    = 4'd10;
  localparam logic [3:0] ST_WS_REP    = 4'd11;
  localparam logic [3:0] ST_WS_LEN    = 4'd12;
  localparam logic [3:0] ST_UNKNOWN   = 4'd13;
  localparam logic [3:0] ST_TRUNC     = 4'd14;

  localparam logic CFG_TS_LEN = 1'b0;
  localparam logic CFG_WS_LEN = 1'b1;

  localparam logic [7:0] TS_LEN_RESET = 8'd10;
  localparam logic [7:0] WS_LEN_RESET = 8'd3;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] sequence_number;
    logic [31:0] ack_number;
    logic [5:0]  header_bytes;
    logic [8:0]  flag_bits;
    logic [15:0] window_size;
    logic [15:0] urgent_pointer;
    logic [15:0] mss_value;
    logic [7:0]  window_shift;
    logic [3:0]  options_seen;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/thv_parser.sv =====
// ----------------------------------------------------------------------------
// thv_parser
// per-byte parser state: header capture, flag checks and option walk
// ----------------------------------------------------------------------------
`default_nettype none

module thv_parser import thv_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic [7:0]  ts_len_i,
  input  wire logic [7:0]  ws_len_i,
  output result_t          result_o
);

  logic [6:0]  pos_q, pos_d;
  phase_e      ph_q, ph_d;
  logic [3:0]  step_q, step_d;
  logic [15:0] src_q, src_d, dst_q, dst_d, win_q, win_d, urg_q, urg_d;
  logic [63:0] sa_q, sa_d;
  logic [15:0] mss_q, mss_d;
  logic [7:0]  shift_q, shift_d;
  logic [3:0]  seen_q, seen_d;
  logic        sent_q, sent_d;
  logic [7:0]  off_q, off_d, flg_q, flg_d, kind_q, kind_d;
  logic [3:0]  err_q, err_d;

  logic [5:0]  hlen;
  logic [8:0]  fl9;
  logic        more;
  logic [3:0]  st;
  logic [3:0]  bit_m;
  logic [3:0]  rep;
  logic        done;

  assign hlen = {off_q[7:4], 2'b00};
  // next kind expected when the following byte is still inside the header
  assign more = ({1'b0, pos_q} + 8'd1) < {2'b00, hlen};

  always_comb begin
    pos_d = pos_q; ph_d = ph_q; step_d = step_q;
    src_d = src_q; dst_d = dst_q; win_d = win_q; urg_d = urg_q;
    sa_d = sa_q; mss_d = mss_q; shift_d = shift_q; seen_d = seen_q;
    sent_d = sent_q; off_d = off_q; flg_d = flg_q; kind_d = kind_q;
    err_d = err_q;
    fl9 = {off_q[0], data_byte_i};
    bit_m = 4'd0; rep = ST_OK; done = 1'b0;
    case (ph_q)
      PH_FIXED: begin
        if (pos_q <= 7'd1) src_d = {src_q[7:0], data_byte_i};
        else if (pos_q <= 7'd3) begin
          dst_d = {dst_q[7:0], data_byte_i};
          // header capture goes on after a port error
          if (pos_q == 7'd3 && !sent_q) begin
            if (src_q == 16'd0) begin
              err_d = ST_SRC0; sent_d = 1'b1;
            end else if (dst_d == 16'd0) begin
              err_d = ST_DST0; sent_d = 1'b1;
            end
          end
        end else if (pos_q <= 7'd11) sa_d = {sa_q[55:0], data_byte_i};
        else if (pos_q == 7'd12) off_d = data_byte_i;
        else if (pos_q == 7'd13) begin
          flg_d = data_byte_i;
          if (!sent_q) begin
            if (fl9 == 9'h1FF) begin
              err_d = ST_ALLFLAGS; sent_d = 1'b1;
            end else if (fl9 == 9'h000) begin
              err_d = ST_NOFLAGS; sent_d = 1'b1;
            end else if (fl9[1:0] == 2'b11) begin
              err_d = ST_SYNFIN; sent_d = 1'b1;
            end
          end
        end else if (pos_q <= 7'd15) win_d = {win_q[7:0], data_byte_i};
        else if (pos_q >= 7'd18) urg_d = {urg_q[7:0], data_byte_i};
        if (pos_q == 7'd19) begin
          if (sent_q) ph_d = PH_DONE;
          else ph_d = more ? PH_KIND : PH_DONE;
        end
      end
      PH_KIND: begin
        case (data_byte_i)
          K_EOL:  ph_d = PH_DONE;
          K_NOP:  ph_d = more ? PH_KIND : PH_DONE;
          K_MSS:  begin bit_m = 4'b0001; rep = ST_MSS_REP; end
          K_SACK: begin bit_m = 4'b0010; rep = ST_SACK_REP; end
          K_TS:   begin bit_m = 4'b0100; rep = ST_TS_REP; end
          K_WS:   begin bit_m = 4'b1000; rep = ST_WS_REP; end
          default: begin
            err_d = ST_UNKNOWN; sent_d = 1'b1; ph_d = PH_DONE;
          end
        endcase
        if (bit_m != 4'd0) begin
          if ((seen_q & bit_m) != 4'd0) begin
            err_d = rep; sent_d = 1'b1; ph_d = PH_DONE;
          end else begin
            seen_d = seen_q | bit_m; kind_d = data_byte_i;
            step_d = 4'd0; ph_d = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        step_d = step_q + 4'd1;
        case (kind_q)
          K_MSS: begin
            if (step_q == 4'd1) mss_d = {data_byte_i, mss_q[7:0]};
            else if (step_q == 4'd2) begin
              mss_d = {mss_q[15:8], data_byte_i}; done = 1'b1;
            end
          end
          K_SACK: done = 1'b1;
          K_TS: begin
            if (step_q == 4'd0 && data_byte_i != ts_len_i) begin
              err_d = ST_TS_LEN; sent_d = 1'b1; ph_d = PH_DONE; step_d = step_q;
            end else if (step_q >= 4'd8) done = 1'b1;
          end
          default: begin
            if (step_q == 4'd0 && data_byte_i != ws_len_i) begin
              err_d = ST_WS_LEN; sent_d = 1'b1; ph_d = PH_DONE; step_d = step_q;
            end else if (step_q == 4'd1) begin
              shift_d = data_byte_i; done = 1'b1;
            end
          end
        endcase
        if (done) ph_d = more ? PH_KIND : PH_DONE;
      end
      default: ;
    endcase
    if (pos_q != 7'd127) pos_d = pos_q + 7'd1;

    if (pos_q < 7'd19) st = ST_SHORT;
    else if (sent_d) st = err_d;
    else if (ph_d == PH_KIND || ph_d == PH_BODY) st = ST_TRUNC;
    else st = ST_OK;

    result_o.status          = st;
    result_o.source_port     = src_d;
    result_o.dest_port       = dst_d;
    result_o.sequence_number = sa_d[63:32];
    result_o.ack_number      = sa_d[31:0];
    result_o.header_bytes    = {off_d[7:4], 2'b00};
    result_o.flag_bits       = {off_d[0], flg_d};
    result_o.window_size     = win_d;
    result_o.urgent_pointer  = urg_d;
    result_o.mss_value       = mss_d;
    result_o.window_shift    = shift_d;
    result_o.options_seen    = seen_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; ph_q <= PH_FIXED; step_q <= '0;
      src_q <= '0; dst_q <= '0; win_q <= '0; urg_q <= '0; sa_q <= '0;
      mss_q <= '0; shift_q <= '0; seen_q <= '0; sent_q <= 1'b0;
      off_q <= '0; flg_q <= '0; kind_q <= '0; err_q <= '0;
    end else if (step_i) begin
      if (last_byte_i) begin
        pos_q <= '0; ph_q <= PH_FIXED; step_q <= '0;
        src_q <= '0; dst_q <= '0; win_q <= '0; urg_q <= '0; sa_q <= '0;
        mss_q <= '0; shift_q <= '0; seen_q <= '0; sent_q <= 1'b0;
        off_q <= '0; flg_q <= '0; kind_q <= '0; err_q <= '0;
      end else begin
        pos_q <= pos_d; ph_q <= ph_d; step_q <= step_d;
        src_q <= src_d; dst_q <= dst_d; win_q <= win_d; urg_q <= urg_d;
        sa_q <= sa_d; mss_q <= mss_d; shift_q <= shift_d; seen_q <= seen_d;
        sent_q <= sent_d; off_q <= off_d; flg_q <= flg_d; kind_q <= kind_d;
        err_q <= err_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tcp_header_validator_core.sv =====
// ----------------------------------------------------------------------------
// tcp_header_validator_core
// byte-serial tcp header and option checker, one result per segment
// ----------------------------------------------------------------------------
// the result is registered and valid in the cycle after the accepted last byte
// throughput: one byte per cycle; only a last byte stalls, and only while
// an earlier result is still held in the stalled result register
// reset: parser state cleared, option lengths return to 10 and 3
`default_nettype none

module tcp_header_validator_core import thv_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       status_o,
  output logic [15:0]      source_port_o,
  output logic [15:0]      dest_port_o,
  output logic [31:0]      sequence_number_o,
  output logic [31:0]      ack_number_o,
  output logic [5:0]       header_bytes_o,
  output logic [8:0]       flag_bits_o,
  output logic [15:0]      window_size_o,
  output logic [15:0]      urgent_pointer_o,
  output logic [15:0]      mss_value_o,
  output logic [7:0]       window_shift_o,
  output logic [3:0]       options_seen_o
);

  logic [7:0] ts_len_q, ws_len_q;
  logic       step;
  result_t    res;
  result_t    res_q;
  logic       vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_len_q <= TS_LEN_RESET;
      ws_len_q <= WS_LEN_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_TS_LEN) ts_len_q <= cfg_data_i;
      else ws_len_q <= cfg_data_i;
    end
  end

  // stall only when a result is held and another would be produced
  assign in_stall_o = vld_q && out_stall_i && last_byte_i;
  assign step = in_valid_i && !in_stall_o;

  thv_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .ts_len_i    (ts_len_q),
    .ws_len_i    (ws_len_q),
    .result_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (!vld_q || !out_stall_i) begin
      vld_q <= step && last_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((!vld_q || !out_stall_i) && step && last_byte_i) res_q <= res;
  end

  assign out_valid_o       = vld_q;
  assign status_o          = res_q.status;
  assign source_port_o     = res_q.source_port;
  assign dest_port_o       = res_q.dest_port;
  assign sequence_number_o = res_q.sequence_number;
  assign ack_number_o      = res_q.ack_number;
  assign header_bytes_o    = res_q.header_bytes;
  assign flag_bits_o       = res_q.flag_bits;
  assign window_size_o     = res_q.window_size;
  assign urgent_pointer_o  = res_q.urgent_pointer;
  assign mss_value_o       = res_q.mss_value;
  assign window_shift_o    = res_q.window_shift;
  assign options_seen_o    = res_q.options_seen;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// byte-serial tcp header validator testbench: segments are built with valid
// headers and option lists, mixed with broken and random ones, and every
// segment result is checked against a behavioural parser in the scoreboard
// ----------------------------------------------------------------------------
`default_nettype none

class seg_scoreboard;
  logic [7:0] ts_len, ws_len;
  logic [6:0] pos;
  thv_pkg::phase_e phase;
  logic [3:0] step, seen, err, kind;
  logic [63:0] hdr, seqack;
  logic [23:0] optv;
  logic sent;
  logic [7:0] offs, flg;
  thv_pkg::result_t results_q[$];
  int errors;

  function new();
    errors = 0;
    ts_len = thv_pkg::TS_LEN_RESET;
    ws_len = thv_pkg::WS_LEN_RESET;
    clear();
  endfunction

  function void clear();
    pos = '0; phase = thv_pkg::PH_FIXED; step = '0; hdr = '0; seqack = '0;
    optv = '0; seen = '0; sent = 1'b0; offs = '0; flg = '0; err = '0; kind = '0;
  endfunction

  function void fail(logic [3:0] code);
    if (!sent) begin
      err = code;
      sent = 1'b1;
    end
    phase = thv_pkg::PH_DONE;
  endfunction

  function logic [5:0] hlen();
    return {offs[7:4], 2'b00};
  endfunction

  function void next_kind(logic [6:0] p);
    phase = (int'(p) + 1 < int'(hlen())) ? thv_pkg::PH_KIND : thv_pkg::PH_DONE;
  endfunction

  function void fixed_byte(logic [6:0] p, logic [7:0] b);
    logic [8:0] f;
    if (p <= 1) hdr[63:48] = {hdr[55:48], b};
    else if (p <= 3) begin
      hdr[47:32] = {hdr[39:32], b};
      if (p == 3 && !sent) begin
        if (hdr[63:48] == 0) fail(thv_pkg::ST_SRC0);
        else if (hdr[47:32] == 0) fail(thv_pkg::ST_DST0);
        phase = thv_pkg::PH_FIXED;
      end
    end else if (p <= 11) seqack = {seqack[55:0], b};
    else if (p == 12) offs = b;
    else if (p == 13) begin
      flg = b;
      if (!sent) begin
        f = {offs[0], flg};
        if (f == 9'h1FF) fail(thv_pkg::ST_ALLFLAGS);
        else if (f == 0) fail(thv_pkg::ST_NOFLAGS);
        else if (f[1:0] == 2'b11) fail(thv_pkg::ST_SYNFIN);
        phase = thv_pkg::PH_FIXED;
      end
    end else if (p <= 15) hdr[31:16] = {hdr[23:16], b};
    else if (p >= 18) hdr[15:0] = {hdr[7:0], b};
    if (p == 19) begin
      if (sent) phase = thv_pkg::PH_DONE;
      else next_kind(p);
    end
  endfunction

  function void kind_byte(logic [6:0] p, logic [7:0] b);
    logic [3:0] bits, rep;
    case (b)
      thv_pkg::K_EOL: begin phase = thv_pkg::PH_DONE; return; end
      thv_pkg::K_NOP: begin next_kind(p); return; end
      thv_pkg::K_MSS: begin bits = 4'h1; rep = thv_pkg::ST_MSS_REP; end
      thv_pkg::K_SACK: begin bits = 4'h2; rep = thv_pkg::ST_SACK_REP; end
      thv_pkg::K_TS: begin bits = 4'h4; rep = thv_pkg::ST_TS_REP; end
      thv_pkg::K_WS: begin bits = 4'h8; rep = thv_pkg::ST_WS_REP; end
      default: begin fail(thv_pkg::ST_UNKNOWN); return; end
    endcase
    if ((seen & bits) != 0) begin
      fail(rep);
      return;
    end
    seen |= bits;
    kind = b[3:0];
    step = 4'd0;
    phase = thv_pkg::PH_BODY;
  endfunction

  function void body_byte(logic [6:0] p, logic [7:0] b);
    logic done;
    done = 1'b0;
    case (kind)
      thv_pkg::K_MSS[3:0]: begin
        if (step == 1) optv[23:16] = b;
        else if (step == 2) begin optv[15:8] = b; done = 1'b1; end
      end
      thv_pkg::K_SACK[3:0]: done = 1'b1;
      thv_pkg::K_TS[3:0]: begin
        if (step == 0 && b != ts_len) begin fail(thv_pkg::ST_TS_LEN); return; end
        if (step >= 8) done = 1'b1;
      end
      default: begin
        if (step == 0 && b != ws_len) begin fail(thv_pkg::ST_WS_LEN); return; end
        if (step == 1) begin optv[7:0] = b; done = 1'b1; end
      end
    endcase
    step = step + 4'd1;
    if (done) next_kind(p);
  endfunction

  function void note_byte(logic [7:0] b, logic last);
    logic [6:0] p;
    thv_pkg::result_t r;
    p = pos;
    case (phase)
      thv_pkg::PH_FIXED: fixed_byte(p, b);
      thv_pkg::PH_KIND: kind_byte(p, b);
      thv_pkg::PH_BODY: body_byte(p, b);
      default: ;
    endcase
    if (pos < 127) pos = pos + 7'd1;
    if (!last) return;
    if (p < 19) r.status = thv_pkg::ST_SHORT;
    else if (sent) r.status = err;
    else if (phase == thv_pkg::PH_KIND || phase == thv_pkg::PH_BODY)
      r.status = thv_pkg::ST_TRUNC;
    else r.status = thv_pkg::ST_OK;
    r.source_port = hdr[63:48];
    r.dest_port = hdr[47:32];
    r.sequence_number = seqack[63:32];
    r.ack_number = seqack[31:0];
    r.header_bytes = hlen();
    r.flag_bits = {offs[0], flg};
    r.window_size = hdr[31:16];
    r.urgent_pointer = hdr[15:0];
    r.mss_value = optv[23:8];
    r.window_shift = optv[7:0];
    r.options_seen = seen;
    results_q.push_back(r);
    clear();
  endfunction

  function void check_result(thv_pkg::result_t got);
    thv_pkg::result_t exp_r;
    if (results_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h", got);
      return;
    end
    exp_r = results_q.pop_front();
    if (got !== exp_r) begin
      errors++;
      if (errors <= 10) $display("mismatch: expected %h actual %h", exp_r, got);
    end
  endfunction
endclass

module tb_top;
  import thv_pkg::*;

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0, cfg_idx_i = 0;
  logic [7:0] cfg_data_i = 0;
  logic in_valid_i = 0, last_byte_i = 0, out_stall_i = 0;
  logic [7:0] data_byte_i = 0;
  logic in_stall_o, out_valid_o;
  result_t res;
  seg_scoreboard sb;
  logic [7:0] seg_q[$];
  int gap_left, hold_req;

  tcp_header_validator_core DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .data_byte_i, .last_byte_i,
    .out_valid_o, .out_stall_i,
    .status_o(res.status), .source_port_o(res.source_port),
    .dest_port_o(res.dest_port), .sequence_number_o(res.sequence_number),
    .ack_number_o(res.ack_number), .header_bytes_o(res.header_bytes),
    .flag_bits_o(res.flag_bits), .window_size_o(res.window_size),
    .urgent_pointer_o(res.urgent_pointer), .mss_value_o(res.mss_value),
    .window_shift_o(res.window_shift), .options_seen_o(res.options_seen)
  );

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: own stall pattern, plus a long hold-off on request
  initial begin
    int mode;
    mode = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) sb.check_result(res);
      if (hold_req > 0) begin
        hold_req--;
        out_stall_i <= 1;
      end else begin
        if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: out_stall_i <= 0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          default: out_stall_i <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (gap_left == 0) begin
      if ($urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 6);
    end
    while (gap_left > 0) begin
      in_valid_i <= 0;
      @(posedge clk_i);
      gap_left--;
    end
    in_valid_i <= 1;
    data_byte_i <= b;
    last_byte_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_byte(b, last);
  endtask

  task automatic send_segment();
    for (int i = 0; i < seg_q.size(); i++) send_byte(seg_q[i], i == seg_q.size() - 1);
    seg_q.delete();
  endtask

  task automatic wait_idle();
    in_valid_i <= 0;
    while (sb.results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [7:0] v);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    if (idx == CFG_TS_LEN) sb.ts_len = v;
    else sb.ws_len = v;
  endtask

  // header with chosen offset, flags and ports
  task automatic build_header(input logic [3:0] doff, input logic [8:0] f,
                              input logic [15:0] sp, input logic [15:0] dp);
    logic [31:0] w;
    seg_q.push_back(sp[15:8]); seg_q.push_back(sp[7:0]);
    seg_q.push_back(dp[15:8]); seg_q.push_back(dp[7:0]);
    for (int k = 0; k < 8; k++) seg_q.push_back(8'($urandom));
    seg_q.push_back({doff, 3'($urandom), f[8]});
    seg_q.push_back(f[7:0]);
    w = $urandom;
    for (int k = 0; k < 4; k++) seg_q.push_back(w[8*k +: 8]);
    w = $urandom;
    seg_q.push_back(w[7:0]); seg_q.push_back(w[15:8]);
  endtask

  task automatic push_option(input int sel);
    case (sel)
      0: seg_q.push_back(K_NOP);
      1: begin
        seg_q.push_back(K_MSS); seg_q.push_back(8'd4);
        seg_q.push_back(8'($urandom)); seg_q.push_back(8'($urandom));
      end
      2: begin seg_q.push_back(K_SACK); seg_q.push_back(8'd2); end
      3: begin
        seg_q.push_back(K_TS);
        seg_q.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : sb.ts_len);
        for (int k = 0; k < 8; k++) seg_q.push_back(8'($urandom));
      end
      4: begin
        seg_q.push_back(K_WS);
        seg_q.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : sb.ws_len);
        seg_q.push_back(8'($urandom));
      end
      5: seg_q.push_back(K_EOL);
      default: seg_q.push_back(8'($urandom));
    endcase
  endtask

  function automatic logic [8:0] good_flags();
    logic [8:0] f;
    f = 9'($urandom);
    if (f == 0) f = 9'h010;
    if (f[1:0] == 2'b11) f[0] = 1'b0;
    return f;
  endfunction

  task automatic random_segment();
    int doff, cut, r;
    logic [8:0] f;
    logic [15:0] sp, dp;
    r = $urandom_range(0, 99);
    sp = 16'($urandom); dp = 16'($urandom);
    if (sp == 0) sp = 16'd1;
    if (dp == 0) dp = 16'd1;
    if (r < 3) sp = 16'd0;
    else if (r < 6) dp = 16'd0;
    f = good_flags();
    if (r >= 6 && r < 12) f = 9'($urandom);
    if (r == 12) f = 9'h1FF;
    doff = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 10);
    build_header(4'(doff), f, sp, dp);
    while (seg_q.size() < doff * 4 + 2)
      push_option(($urandom_range(0, 15) == 0) ? 6 : $urandom_range(0, 5));
    repeat ($urandom_range(0, 3)) seg_q.push_back(8'($urandom));
    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, seg_q.size());
      while (seg_q.size() > cut) void'(seg_q.pop_back());
    end
    send_segment();
  endtask

  initial begin
    sb = new();
    gap_left = 0;
    hold_req = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed segments
    build_header(4'd5, 9'h010, 16'hFFFF, 16'hFFFF); send_segment();
    build_header(4'd5, 9'h010, 16'd0, 16'h0001); send_segment();
    build_header(4'd5, 9'h010, 16'h0001, 16'd0); send_segment();
    build_header(4'd5, 9'h1FF, 16'd1, 16'd1); send_segment();
    build_header(4'd5, 9'h000, 16'd1, 16'd1); send_segment();
    build_header(4'd5, 9'h003, 16'd1, 16'd1); send_segment();
    build_header(4'd2, 9'h100, 16'd1, 16'd1); send_segment();
    build_header(4'd15, 9'h002, 16'd1, 16'd1);
    for (int s = 0; s < 5; s++) push_option(s == 0 ? 1 : s);
    push_option(5); push_option(6);
    while (seg_q.size() < 130) seg_q.push_back(8'hFF);
    send_segment();
    build_header(4'd8, 9'h002, 16'd1, 16'd1); push_option(1); push_option(1);
    send_segment();
    build_header(4'd8, 9'h002, 16'd1, 16'd1); push_option(2); push_option(2);
    send_segment();
    build_header(4'd10, 9'h002, 16'd1, 16'd1); push_option(3); push_option(3);
    send_segment();
    build_header(4'd8, 9'h002, 16'd1, 16'd1); push_option(4); push_option(4);
    send_segment();
    build_header(4'd8, 9'h002, 16'd1, 16'd1); seg_q.push_back(8'd99); send_segment();
    build_header(4'd8, 9'h002, 16'd1, 16'd1); seg_q.push_back(K_TS);
    seg_q.push_back(8'd0);
    send_segment();
    build_header(4'd8, 9'h002, 16'd1, 16'd1); seg_q.push_back(K_WS);
    seg_q.push_back(8'd0);
    send_segment();
    build_header(4'd6, 9'h002, 16'd1, 16'd1); push_option(1); send_segment();
    build_header(4'd7, 9'h002, 16'd1, 16'd1); push_option(1); send_segment();
    build_header(4'd6, 9'h002, 16'd1, 16'd1); seg_q.push_back(K_MSS); send_segment();
    seg_q.push_back(8'h12); send_segment();

    // register extremes
    wait_idle();
    write_cfg(CFG_TS_LEN, 8'd0); write_cfg(CFG_WS_LEN, 8'hFF);
    build_header(4'd9, 9'h002, 16'd1, 16'd1); push_option(3); push_option(4);
    send_segment();
    wait_idle();
    write_cfg(CFG_TS_LEN, 8'hFF); write_cfg(CFG_WS_LEN, 8'd0);
    build_header(4'd9, 9'h002, 16'd1, 16'd1); push_option(3); push_option(4);
    send_segment();
    wait_idle();
    write_cfg(CFG_TS_LEN, TS_LEN_RESET); write_cfg(CFG_WS_LEN, WS_LEN_RESET);

    for (int n = 0; n < 14; n++) begin
      if (n == 3) hold_req = 300;
      if (n == 5 || n == 10) begin
        wait_idle();
        write_cfg(CFG_TS_LEN, 8'($urandom)); write_cfg(CFG_WS_LEN, 8'($urandom));
      end
      random_segment();
    end
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.results_q.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

`default_nettype wire
